// ----- rtl/lba_to_chs_floppy_command_sequencer_top_macros.svh -----
// assertion macros for the floppy command sequencer
`ifndef LBA_TO_CHS_FLOPPY_COMMAND_SEQUENCER_TOP_MACROS_SVH
`define LBA_TO_CHS_FLOPPY_COMMAND_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define LCS_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sequencer check failed: same cycle");

// next-cycle implication, clocked on clk, off during rst
`define LCS_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sequencer check failed: next cycle");

`endif

// ----- rtl/lba2chs_pkg.sv -----
// types and constants for the floppy command sequencer
package lba2chs_pkg;

  localparam int NUM_W      = 16;
  localparam int SPT_W      = 6;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = NUM_W / DIV_STEPS;
  localparam int ADDR_W     = 5;

  localparam logic [7:0] OP_RECALIBRATE = 8'd7;
  localparam logic [7:0] OP_SEEK        = 8'd15;
  localparam logic [7:0] OP_READ        = 8'd230;
  localparam logic [7:0] SIZE_CODE      = 8'd2;
  localparam logic [7:0] READ_TAIL      = 8'hFF;

  // multiply-and-shift reciprocal for division by three
  localparam logic [16:0] RECIP_THREE = 17'h0AAAB;
  localparam int          RECIP_SHIFT = 17;

  // register indexes
  localparam logic [2:0] REG_HEAD_COUNT  = 3'd0;
  localparam logic [2:0] REG_TRACK_COUNT = 3'd1;
  localparam logic [2:0] REG_SPT         = 3'd2;
  localparam logic [2:0] REG_STRETCH     = 3'd3;
  localparam logic [2:0] REG_GAP         = 3'd4;
  localparam logic [2:0] REG_DRIVE       = 3'd5;

  // byte positions within a run
  localparam logic [3:0] POS_RECAL       = 4'd0;
  localparam logic [3:0] POS_RECAL_DRIVE = 4'd1;
  localparam logic [3:0] POS_SEEK        = 4'd2;
  localparam logic [3:0] POS_SEEK_DRIVE  = 4'd3;
  localparam logic [3:0] POS_SEEK_TRACK  = 4'd4;
  localparam logic [3:0] POS_READ        = 4'd5;
  localparam logic [3:0] POS_READ_DRIVE  = 4'd6;
  localparam logic [3:0] POS_TRACK       = 4'd7;
  localparam logic [3:0] POS_HEAD        = 4'd8;
  localparam logic [3:0] POS_SECTOR      = 4'd9;
  localparam logic [3:0] POS_SIZE        = 4'd10;
  localparam logic [3:0] POS_LAST_SECTOR = 4'd11;
  localparam logic [3:0] POS_GAP         = 4'd12;
  localparam logic [3:0] POS_TAIL        = 4'd13;

  typedef struct packed {
    logic [SPT_W-1:0] rem;
    logic [NUM_W-1:0] work;
    logic [NUM_W-1:0] num;
  } div_stage_t;

endpackage

// ----- rtl/lba_to_chs_floppy_command_sequencer_top.sv -----
// sector number to chs conversion and floppy read command byte sequencer
// the divider stages, range check and head split can take new sectors while a run is emitted, until they fill
// output: one command byte per cycle while command_stall is low, fourteen bytes per sector
// pipeline: four divider stages, range check, head split, run buffer, output register
// out-of-range sector numbers are dropped inside the pipeline and give no bytes
// reset: synchronous, loads register defaults and empties every stage
`include "lba_to_chs_floppy_command_sequencer_top_macros.svh"

module lba_to_chs_floppy_command_sequencer_top
  import lba2chs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              sector_valid,
  output logic              sector_stall,
  input  logic [NUM_W-1:0]  sector_number,
  output logic              command_valid,
  input  logic              command_stall,
  output logic [7:0]        command_byte,
  output logic              last_byte
);

  logic [1:0]       head_count;
  logic [7:0]       track_count;
  logic [SPT_W-1:0] sectors_per_track;
  logic             track_stretch;
  logic [7:0]       gap_length;
  logic [1:0]       drive_select;

  logic             cfg_write;
  logic [9:0]       head_tracks;
  logic [NUM_W-1:0] limit;

  div_stage_t       stg [1:DIV_STAGES];
  div_stage_t       stg_init;
  logic [DIV_STAGES:1] dvld;
  logic [DIV_STAGES:1] drdy;

  logic             v5;
  logic             inr5;
  logic [NUM_W-1:0] block5;
  logic [NUM_W-1:0] third5;
  logic [SPT_W-1:0] rem5;
  logic [32:0]      third_prod;
  logic             rdy5;

  logic             v6;
  logic [7:0]       track6;
  logic [1:0]       head6;
  logic [SPT_W-1:0] sector6;
  logic             rdy6;
  logic [NUM_W-1:0] triple5;

  logic             busy;
  logic [3:0]       pos;
  logic [7:0]       run_track;
  logic [1:0]       run_head;
  logic [SPT_W-1:0] run_sector;
  logic             out_load;
  logic             last_pos;
  logic             emit_fire;
  logic             emit_free;
  logic             take;
  logic [7:0]       byte_next;

  function automatic div_stage_t div_step4(div_stage_t s, logic [SPT_W-1:0] d);
    div_stage_t       r;
    logic [SPT_W:0]   t;
    r = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r.rem, r.work[NUM_W-1]};
      if (t >= {1'b0, d}) begin
        r.rem  = SPT_W'(t - {1'b0, d});
        r.work = {r.work[NUM_W-2:0], 1'b1};
      end else begin
        r.rem  = t[SPT_W-1:0];
        r.work = {r.work[NUM_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_count        <= 2'd2;
      track_count       <= 8'd80;
      sectors_per_track <= 6'd18;
      track_stretch     <= 1'b0;
      gap_length        <= 8'd27;
      drive_select      <= 2'd0;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_HEAD_COUNT:  head_count        <= pwdata[1:0];
        REG_TRACK_COUNT: track_count       <= pwdata[7:0];
        REG_SPT:         sectors_per_track <= pwdata[SPT_W-1:0];
        REG_STRETCH:     track_stretch     <= pwdata[0];
        REG_GAP:         gap_length        <= pwdata[7:0];
        REG_DRIVE:       drive_select      <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_HEAD_COUNT:  prdata = 32'(head_count);
      REG_TRACK_COUNT: prdata = 32'(track_count);
      REG_SPT:         prdata = 32'(sectors_per_track);
      REG_STRETCH:     prdata = 32'(track_stretch);
      REG_GAP:         prdata = 32'(gap_length);
      REG_DRIVE:       prdata = 32'(drive_select);
      default:         prdata = '0;
    endcase
  end

  // geometry product, follows the registers
  always_ff @(posedge clk) begin
    head_tracks <= 10'(head_count * track_count);
    limit       <= NUM_W'(head_tracks * sectors_per_track);
  end

  // ready chain
  assign rdy6 = !v6 || emit_free;
  assign rdy5 = !v5 || rdy6;

  always_comb begin
    drdy[DIV_STAGES] = !dvld[DIV_STAGES] || rdy5;
    for (int k = DIV_STAGES - 1; k >= 1; k--) begin
      drdy[k] = !dvld[k] || drdy[k+1];
    end
  end

  assign sector_stall = !drdy[1];

  // divider stages, sector number by sectors per track
  assign stg_init = '{rem: '0, work: sector_number, num: sector_number};

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld <= '0;
    end else begin
      if (drdy[1]) dvld[1] <= sector_valid;
      for (int k = 2; k <= DIV_STAGES; k++) begin
        if (drdy[k]) dvld[k] <= dvld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drdy[1]) stg[1] <= div_step4(stg_init, sectors_per_track);
    for (int k = 2; k <= DIV_STAGES; k++) begin
      if (drdy[k]) stg[k] <= div_step4(stg[k-1], sectors_per_track);
    end
  end

  // range check and division of the block by three
  assign third_prod = 33'(stg[DIV_STAGES].work) * 33'(RECIP_THREE);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= dvld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      inr5   <= stg[DIV_STAGES].num < limit;
      block5 <= stg[DIV_STAGES].work;
      third5 <= third_prod[RECIP_SHIFT +: NUM_W];
      rem5   <= stg[DIV_STAGES].rem;
    end
  end

  // head and track split
  assign triple5 = third5 + {third5[NUM_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (rdy6) begin
      v6 <= v5 && inr5;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      sector6 <= rem5 + 1'b1;
      unique case (head_count)
        2'd2: begin
          track6 <= block5[8:1];
          head6  <= {1'b0, block5[0]};
        end
        2'd3: begin
          track6 <= third5[7:0];
          head6  <= 2'(block5 - triple5);
        end
        default: begin
          track6 <= block5[7:0];
          head6  <= 2'd0;
        end
      endcase
    end
  end

  // run buffer and byte sequencer
  assign out_load  = !command_valid || !command_stall;
  assign last_pos  = (pos == POS_TAIL);
  assign emit_fire = busy && out_load;
  assign emit_free = !busy || (last_pos && out_load);
  assign take      = v6 && emit_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_RECAL;
    end else if (take) begin
      busy <= 1'b1;
      pos  <= POS_RECAL;
    end else if (emit_fire) begin
      pos <= pos + 1'b1;
      if (last_pos) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      run_track  <= track6;
      run_head   <= head6;
      run_sector <= sector6;
    end
  end

  always_comb begin
    unique case (pos)
      POS_RECAL:       byte_next = OP_RECALIBRATE;
      POS_RECAL_DRIVE: byte_next = 8'(drive_select);
      POS_SEEK:        byte_next = OP_SEEK;
      POS_SEEK_DRIVE:  byte_next = 8'(drive_select);
      POS_SEEK_TRACK:  byte_next = track_stretch ? {run_track[6:0], 1'b0} : run_track;
      POS_READ:        byte_next = OP_READ;
      POS_READ_DRIVE:  byte_next = 8'(drive_select);
      POS_TRACK:       byte_next = run_track;
      POS_HEAD:        byte_next = 8'(run_head);
      POS_SECTOR:      byte_next = 8'(run_sector);
      POS_SIZE:        byte_next = SIZE_CODE;
      POS_LAST_SECTOR: byte_next = 8'(sectors_per_track);
      POS_GAP:         byte_next = gap_length;
      POS_TAIL:        byte_next = READ_TAIL;
      default:         byte_next = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      command_valid <= 1'b0;
    end else if (out_load) begin
      command_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      command_byte <= byte_next;
      last_byte    <= last_pos;
    end
  end

  // checks
  `LCS_ASSERT_NXT(a_drop_out_of_range, v5 && !inr5 && rdy6, !v6)
  `LCS_ASSERT_IMP(a_remainder_below_divisor, v5 && inr5, rem5 < sectors_per_track)
  `LCS_ASSERT_NXT(a_emit_reaches_port, emit_fire, command_valid)
  `LCS_ASSERT_IMP(a_run_position_bound, busy, pos <= POS_TAIL)

endmodule

// ----- test/tb_lba_to_chs_floppy_command_sequencer_top.sv -----
// testbench for the sector number to floppy read command byte sequencer
`timescale 1ns / 100ps

module tb_lba_to_chs_floppy_command_sequencer_top;
  import lba2chs_pkg::*;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int RUN_BYTES = 14;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cmd_byte_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              sector_valid = 1'b0;
  logic              sector_stall;
  logic [NUM_W-1:0]  sector_number = '0;
  logic              command_valid;
  logic              command_stall = 1'b0;
  logic [7:0]        command_byte;
  logic              last_byte;

  logic [1:0]       cfg_heads = 2'd2;
  logic [7:0]       cfg_tracks = 8'd80;
  logic [SPT_W-1:0] cfg_spt = 6'd18;
  logic             cfg_stretch = 1'b0;
  logic [7:0]       cfg_gap = 8'd27;
  logic [1:0]       cfg_drive = 2'd0;

  cmd_byte_t cmd_bytes_q [$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;

  lba_to_chs_floppy_command_sequencer_top u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .sector_valid  (sector_valid),
    .sector_stall  (sector_stall),
    .sector_number (sector_number),
    .command_valid (command_valid),
    .command_stall (command_stall),
    .command_byte  (command_byte),
    .last_byte     (last_byte)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int gap_cycles();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic queue_read_commands(input logic [NUM_W-1:0] number);
    int unsigned sector_limit;
    int unsigned block;
    logic [7:0]  trk;
    logic [7:0]  head;
    logic [7:0]  sec;
    logic [7:0]  seek_trk;
    logic [7:0]  run_bytes [RUN_BYTES];
    sector_limit = 32'(cfg_heads) * 32'(cfg_tracks) * 32'(cfg_spt);
    if (32'(number) >= sector_limit) return;
    sec = 8'(32'(number) % 32'(cfg_spt) + 1);
    block = 32'(number) / 32'(cfg_spt);
    trk = 8'(block / 32'(cfg_heads));
    head = 8'(block % 32'(cfg_heads));
    seek_trk = trk << cfg_stretch;
    run_bytes = '{OP_RECALIBRATE, 8'(cfg_drive), OP_SEEK, 8'(cfg_drive), seek_trk,
                  OP_READ, 8'(cfg_drive), trk, head, sec, SIZE_CODE, 8'(cfg_spt),
                  cfg_gap, READ_TAIL};
    for (int k = 0; k < RUN_BYTES; k++) begin
      cmd_bytes_q.push_back('{data: run_bytes[k], last: (k == RUN_BYTES - 1)});
    end
  endtask

  task automatic write_register(input logic [2:0] index, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (index)
      REG_HEAD_COUNT:  cfg_heads = value[1:0];
      REG_TRACK_COUNT: cfg_tracks = value[7:0];
      REG_SPT:         cfg_spt = value[SPT_W-1:0];
      REG_STRETCH:     cfg_stretch = value[0];
      REG_GAP:         cfg_gap = value[7:0];
      REG_DRIVE:       cfg_drive = value[1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_geometry(input int heads, input int tracks, input int spt,
                              input int stretch, input int gap, input int drive);
    write_register(REG_HEAD_COUNT, {30'($urandom()), 2'(heads)});
    write_register(REG_TRACK_COUNT, {24'($urandom()), 8'(tracks)});
    write_register(REG_SPT, {26'($urandom()), 6'(spt)});
    write_register(REG_STRETCH, {31'($urandom()), 1'(stretch)});
    write_register(REG_GAP, {24'($urandom()), 8'(gap)});
    write_register(REG_DRIVE, {30'($urandom()), 2'(drive)});
  endtask

  task automatic send_sector(input logic [NUM_W-1:0] number);
    @(negedge clk);
    if (!calm && $urandom_range(0, 2) == 0) begin
      sector_valid <= 1'b0;
      repeat (gap_cycles()) @(negedge clk);
    end
    sector_valid <= 1'b1;
    sector_number <= number;
    @(posedge clk);
    while (sector_stall) @(posedge clk);
    queue_read_commands(number);
  endtask

  task automatic drain();
    @(negedge clk);
    sector_valid <= 1'b0;
    while (cmd_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_default_geometry();
    send_sector(16'd0);
    send_sector(16'd1);
    send_sector(16'd17);
    send_sector(16'd18);
    send_sector(16'd35);
    send_sector(16'd36);
    send_sector(16'd2879);
    send_sector(16'd2880);
    send_sector(16'hFFFF);
    drain();
  endtask

  task automatic test_register_extremes();
    set_geometry(1, 1, 1, 0, 0, 0);
    send_sector(16'd0);
    send_sector(16'd1);
    drain();
    set_geometry(1, 255, 63, 1, 255, 3);
    write_register(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_register(REG_SPARE_HI, 32'h0000_0000);
    send_sector(16'd0);
    send_sector(16'd16064);
    send_sector(16'd16065);
    drain();
    write_register(REG_HEAD_COUNT, 32'hFFFF_FFFF);
    send_sector(16'd24192);
    send_sector(16'd48194);
    send_sector(16'd48195);
    drain();
  endtask

  task automatic test_degenerate_geometry();
    set_geometry(0, 80, 18, 0, 27, 1);
    send_sector(16'd0);
    drain();
    set_geometry(2, 0, 18, 0, 27, 2);
    send_sector(16'd1);
    drain();
    set_geometry(2, 80, 0, 1, 27, 0);
    send_sector(16'd2);
    drain();
  endtask

  task automatic test_random_requests();
    int unsigned sector_limit;
    int          heads;
    int          tracks;
    int          spt;
    int          calm_from;
    logic [NUM_W-1:0] number;
    for (int phase = 0; phase < 6; phase++) begin
      heads = ($urandom_range(0, 5) == 0) ? 3 : $urandom_range(1, 2);
      tracks = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 255);
      spt = ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(1, 63);
      set_geometry(heads, tracks, spt, $urandom_range(0, 1), $urandom_range(0, 255),
                   $urandom_range(0, 3));
      sector_limit = 32'(cfg_heads) * 32'(cfg_tracks) * 32'(cfg_spt);
      calm_from = $urandom_range(0, 40);
      for (int i = 0; i < 50; i++) begin
        calm = (i >= calm_from && i < calm_from + 10);
        if (phase == 2 && i == 25) drain();
        if (sector_limit > 0 && $urandom_range(0, 4) != 0) begin
          number = NUM_W'($urandom_range(0, sector_limit - 1));
        end else begin
          number = NUM_W'($urandom());
        end
        send_sector(number);
      end
      calm = 1'b0;
      drain();
    end
  endtask

  always @(negedge clk) begin
    if (rst || calm) begin
      command_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      command_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      command_stall <= 1'b1;
      stall_left = gap_cycles() - 1;
    end else begin
      command_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cmd_byte_t want;
    if (!rst && command_valid && !command_stall) begin
      if (cmd_bytes_q.size() == 0) begin
        mismatches++;
        $display("%0t: command byte expected none actual %02h last %0b", $time,
                 command_byte, last_byte);
      end else begin
        want = cmd_bytes_q.pop_front();
        if (command_byte !== want.data) begin
          mismatches++;
          $display("%0t: command_byte expected %02h actual %02h", $time, want.data,
                   command_byte);
        end
        if (last_byte !== want.last) begin
          mismatches++;
          $display("%0t: last_byte expected %0b actual %0b", $time, want.last,
                   last_byte);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sector_valid && !sector_stall) || (command_valid && !command_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_default_geometry();
    test_register_extremes();
    test_degenerate_geometry();
    test_random_requests();
    drain();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- lba_to_chs_floppy_command_sequencer_top.f -----
+incdir+rtl
rtl/lba2chs_pkg.sv
rtl/lba_to_chs_floppy_command_sequencer_top.sv
test/tb_lba_to_chs_floppy_command_sequencer_top.sv
